FILE: src/kfat_pkg.sv
// ----------------------------------------------------------------------------
// kfat_pkg
// Shared types and constants of the keyed force accumulator table.
// ----------------------------------------------------------------------------
package kfat_pkg;

   localparam int KeyWidth    = 24;
   localparam int TypeWidth   = 8;
   localparam int ForceWidth  = 32;
   localparam int StatusWidth = 3;
   localparam int CountWidth  = 6;

   typedef enum logic [1:0] {
      CMD_CLEAR  = 2'd0,
      CMD_ADD    = 2'd1,
      CMD_DIVIDE = 2'd2,
      CMD_DUMP   = 2'd3
   } cmd_type;

   typedef enum logic [StatusWidth-1:0] {
      ST_MERGED   = 3'd0,
      ST_APPENDED = 3'd1,
      ST_FULL     = 3'd2,
      ST_DIVZERO  = 3'd3,
      ST_DONE     = 3'd4
   } status_type;

   // One stored entry.
   typedef struct packed {
      logic [KeyWidth-1:0]   partner;
      logic [TypeWidth-1:0]  kind;
      logic [ForceWidth-1:0] force_q;
   } slot_type;

   // Request word.
   typedef struct packed {
      logic [1:0]            command;
      logic [KeyWidth-1:0]   partner_id;
      logic [TypeWidth-1:0]  type_bits;
      logic [ForceWidth-1:0] force_value;
      logic [ForceWidth-1:0] divisor_value;
   } req_type;

   // Response word.
   typedef struct packed {
      logic [StatusWidth-1:0] status;
      logic                   entry_valid;
      logic [KeyWidth-1:0]    entry_partner;
      logic [TypeWidth-1:0]   entry_type;
      logic [ForceWidth-1:0]  entry_force;
      logic [CountWidth-1:0]  entry_count;
      logic                   last;
   } rsp_type;

   // Divider handshake: start, busy and finish.
   typedef struct packed {
      logic                   start;
      logic                   busy;
      logic                   done;
   } div_ctl_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_SEARCH_RD,
      S_SEARCH_CHK,
      S_APPEND,
      S_MERGE,
      S_DIV_RD,
      S_DIV_START,
      S_DIV_WAIT,
      S_DUMP_RD,
      S_DUMP_OUT,
      S_RESP
   } state_type;

endpackage

FILE: src/kfat_if.sv
// ----------------------------------------------------------------------------
// kfat_if
// Valid/ready channel carrying one word of a given type.
// ----------------------------------------------------------------------------
interface kfat_if #(parameter type word_type = logic) ();
   logic     valid;
   logic     ready;
   word_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

FILE: src/keyed_force_accumulator_table.sv
// ----------------------------------------------------------------------------
// keyed_force_accumulator_table
// Per-atom interaction table keyed by partner id.
// ----------------------------------------------------------------------------
// One word is worked on at a time, and a new request word is taken only once
// the previous response word has left the output register. Clear empties the
// table. Add searches the stored keys, read from a memory with one write and
// one registered read port, one held entry after another (read, then compare),
// plus a read-modify-write. Divide runs every entry through a bit-serial
// divider (read, start, 48 quotient bits, then register the result). Dump
// gives one word per stored entry, each loaded once the output register is
// free.
// ----------------------------------------------------------------------------
module keyed_force_accumulator_table
   import kfat_pkg::*;
#(
   parameter int CAPACITY = 32
) (
   input  logic clock,
   input  logic reset,
   kfat_if.sink   req,
   kfat_if.source rsp
);
   localparam int AddrWidth = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

   state_type state_ff, state_in;
   req_type   cur_ff, cur_in;
   logic [CountWidth:0] count_ff, count_in;
   logic [CountWidth:0] idx_ff, idx_in;
   rsp_type   out_ff, out_in;
   logic      ovalid_ff, ovalid_in;

   logic      wr_en;
   slot_type  wr_data, rd_data;
   logic [AddrWidth-1:0] wr_addr, rd_addr;
   div_ctl_type div_ctl;
   logic      div_start, div_done;
   logic signed [ForceWidth-1:0] quotient;
   logic [ForceWidth:0] sum;

   kfat_table_mem #(.Depth(CAPACITY), .AddrWidth(AddrWidth)) u_mem (
      .clock, .wr_en, .wr_addr, .wr_data, .rd_addr, .rd_data
   );

   kfat_divider u_div (
      .clock, .reset,
      .start(div_start),
      .numer(rd_data.force_q),
      .denom(cur_ff.divisor_value),
      .done(div_done),
      .quotient
   );
   assign div_ctl = '{start: div_start, busy: (state_ff == S_DIV_WAIT), done: div_done};

   assign req.ready = (state_ff == S_IDLE) && !ovalid_ff;
   assign rsp.valid = ovalid_ff;
   assign rsp.data  = out_ff;

   // Saturating add of the merged force.
   assign sum = {rd_data.force_q[ForceWidth-1], rd_data.force_q}
              + {cur_ff.force_value[ForceWidth-1], cur_ff.force_value};

   always_comb begin
      state_in  = state_ff;
      cur_in    = cur_ff;
      count_in  = count_ff;
      idx_in    = idx_ff;
      out_in    = out_ff;
      ovalid_in = ovalid_ff;
      wr_en     = 1'b0;
      wr_addr   = idx_ff[AddrWidth-1:0];
      wr_data   = rd_data;
      rd_addr   = idx_ff[AddrWidth-1:0];
      div_start = 1'b0;
      if (ovalid_ff && rsp.ready) begin
         ovalid_in = 1'b0;
      end
      unique case (state_ff)
         S_IDLE: begin
            if (req.valid && !ovalid_ff) begin
               cur_in = req.data;
               idx_in = '0;
               out_in = '0;
               out_in.status = ST_DONE;
               out_in.last = 1'b1;
               unique case (cmd_type'(req.data.command))
                  CMD_CLEAR: begin
                     count_in = '0;
                     state_in = S_RESP;
                  end
                  CMD_ADD:    state_in = S_SEARCH_RD;
                  CMD_DIVIDE: begin
                     if (req.data.divisor_value == '0) begin
                        out_in.status = ST_DIVZERO;
                        state_in = S_RESP;
                     end else begin
                        state_in = S_DIV_RD;
                     end
                  end
                  CMD_DUMP:   state_in = S_DUMP_RD;
                  default:    state_in = S_RESP;
               endcase
            end
         end
         S_SEARCH_RD: begin
            if (idx_ff == count_ff) begin
               state_in = S_APPEND;
            end else begin
               state_in = S_SEARCH_CHK;
            end
         end
         S_SEARCH_CHK: begin
            if (rd_data.partner == cur_ff.partner_id) begin
               state_in = S_MERGE;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = S_SEARCH_RD;
            end
         end
         S_MERGE: begin
            wr_en = 1'b1;
            wr_data.kind = rd_data.kind | cur_ff.type_bits;
            if (sum[ForceWidth] != sum[ForceWidth-1]) begin
               wr_data.force_q = sum[ForceWidth] ? {1'b1, {(ForceWidth-1){1'b0}}}
                                                 : {1'b0, {(ForceWidth-1){1'b1}}};
            end else begin
               wr_data.force_q = sum[ForceWidth-1:0];
            end
            out_in.status = ST_MERGED;
            state_in = S_RESP;
         end
         S_APPEND: begin
            if (count_ff == (CountWidth+1)'(CAPACITY)) begin
               out_in.status = ST_FULL;
            end else begin
               wr_en = 1'b1;
               wr_data = '{partner: cur_ff.partner_id, kind: cur_ff.type_bits,
                           force_q: cur_ff.force_value};
               count_in = count_ff + 1'b1;
               out_in.status = ST_APPENDED;
            end
            state_in = S_RESP;
         end
         S_DIV_RD: begin
            if (idx_ff == count_ff) begin
               state_in = S_RESP;
            end else begin
               state_in = S_DIV_START;
            end
         end
         S_DIV_START: begin
            div_start = 1'b1;
            state_in = S_DIV_WAIT;
         end
         S_DIV_WAIT: begin
            if (div_ctl.done) begin
               wr_en = 1'b1;
               wr_data.force_q = quotient;
               idx_in = idx_ff + 1'b1;
               state_in = S_DIV_RD;
            end
         end
         S_DUMP_RD: begin
            if (count_ff == '0) begin
               state_in = S_RESP;
            end else begin
               state_in = S_DUMP_OUT;
            end
         end
         S_DUMP_OUT: begin
            // Wait for the output register to drain, then load one entry.
            if (!ovalid_ff || rsp.ready) begin
               ovalid_in = 1'b1;
               out_in.status = ST_DONE;
               out_in.entry_valid = 1'b1;
               out_in.entry_partner = rd_data.partner;
               out_in.entry_type = rd_data.kind;
               out_in.entry_force = rd_data.force_q;
               out_in.entry_count = count_ff[CountWidth-1:0];
               out_in.last = (idx_ff + 1'b1 == count_ff);
               idx_in = idx_ff + 1'b1;
               state_in = (idx_ff + 1'b1 == count_ff) ? S_IDLE : S_DUMP_RD;
            end
         end
         S_RESP: begin
            if (!ovalid_ff || rsp.ready) begin
               ovalid_in = 1'b1;
               out_in.entry_count = count_ff[CountWidth-1:0];
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      idx_ff <= idx_in;
      out_ff <= out_in;
      if (reset) begin
         state_ff  <= S_IDLE;
         count_ff  <= '0;
         ovalid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         ovalid_ff <= ovalid_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      count_ff <= (CountWidth+1)'(CAPACITY))
      else $error("count above capacity");
   assert property (@(posedge clock) disable iff (reset)
      wr_en && (state_ff == S_APPEND) |=> count_ff == $past(count_ff) + 1'b1)
      else $error("append without count step");
   assert property (@(posedge clock) disable iff (reset)
      div_ctl.done |-> div_ctl.busy)
      else $error("divider result outside wait");
endmodule

FILE: src/kfat_divider.sv
// ----------------------------------------------------------------------------
// kfat_divider
// Restoring signed divider: (force << 16) / divisor, truncated toward zero and
// saturated to 32 bits. One quotient bit per cycle, 48 quotient bits.
// ----------------------------------------------------------------------------
module kfat_divider
   import kfat_pkg::*;
(
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic signed [ForceWidth-1:0] numer,
   input  logic signed [ForceWidth-1:0] denom,
   output logic                         done,
   output logic signed [ForceWidth-1:0] quotient
);
   localparam int NumWidth = ForceWidth + 16;

   logic [NumWidth-1:0]   num_ff, num_in;
   logic [ForceWidth-1:0] den_ff, den_in;
   logic [ForceWidth:0]   rem_ff, rem_in;
   logic [NumWidth-1:0]   quo_ff, quo_in;
   logic                  neg_ff, neg_in;
   logic [5:0]            cnt_ff, cnt_in;
   logic                  run_ff, run_in;
   logic                  done_ff, done_in;
   logic [ForceWidth:0]   trial;
   logic [NumWidth:0]     signed_q;

   always_comb begin
      num_in  = num_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      neg_in  = neg_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      trial   = {rem_ff[ForceWidth-1:0], num_ff[NumWidth-1]};
      if (start) begin
         // Work on magnitudes, remember the sign of the result.
         num_in = numer[ForceWidth-1] ? (~{numer, 16'd0} + NumWidth'(1)) : {numer, 16'd0};
         den_in = denom[ForceWidth-1] ? (~denom + ForceWidth'(1)) : denom;
         neg_in = numer[ForceWidth-1] ^ denom[ForceWidth-1];
         rem_in = '0;
         quo_in = '0;
         cnt_in = 6'(NumWidth);
         run_in = 1'b1;
      end else if (run_ff) begin
         // One quotient bit a cycle.
         num_in = {num_ff[NumWidth-2:0], 1'b0};
         if (trial >= {1'b0, den_ff}) begin
            rem_in = trial - {1'b0, den_ff};
            quo_in = {quo_ff[NumWidth-2:0], 1'b1};
         end else begin
            rem_in = trial;
            quo_in = {quo_ff[NumWidth-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      neg_ff <= neg_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
   end

   // Apply the sign and saturate.
   always_comb begin
      signed_q = neg_ff ? (~{1'b0, quo_ff} + (NumWidth+1)'(1)) : {1'b0, quo_ff};
      if (!signed_q[NumWidth] && (signed_q[NumWidth-1:ForceWidth-1] != '0)) begin
         quotient = {1'b0, {(ForceWidth-1){1'b1}}};
      end else if (signed_q[NumWidth] && (signed_q[NumWidth-1:ForceWidth-1] != '1)) begin
         quotient = {1'b1, {(ForceWidth-1){1'b0}}};
      end else begin
         quotient = signed_q[ForceWidth-1:0];
      end
   end
   assign done = done_ff;

   assert property (@(posedge clock) disable iff (reset) done |-> !run_ff)
      else $error("divider done while running");
   assert property (@(posedge clock) disable iff (reset) start |=> run_ff)
      else $error("divider did not start");
   assert property (@(posedge clock) disable iff (reset) run_ff |-> cnt_ff != 6'd0)
      else $error("divider count underflow");
endmodule

FILE: src/kfat_table_mem.sv
// ----------------------------------------------------------------------------
// kfat_table_mem
// Entry store: one write and one registered read port.
// ----------------------------------------------------------------------------
module kfat_table_mem
   import kfat_pkg::*;
#(
   parameter int Depth = 32,
   parameter int AddrWidth = 5
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [AddrWidth-1:0] wr_addr,
   input  slot_type             wr_data,
   input  logic [AddrWidth-1:0] rd_addr,
   output slot_type             rd_data
);
   slot_type mem [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
